/* sv/srs_pkg.sv */
// Shared types, constants and index helpers for the searchable reversible stack.
package srs_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int COUNT_W = 7;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  localparam cnt_t DEPTH_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_SEARCH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } pair_t;

  typedef struct packed {
    logic               ok;
    pair_t              pair;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    pair_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  // Physical slot of logical position idx in the circular store.
  // Forward orientation grows upwards from base, reversed grows downwards.
  function automatic addr_t phys_idx(input addr_t base, input logic rev, input cnt_t idx);
    logic [CW:0] b;
    logic [CW:0] i;
    logic [CW:0] s;
    b = {{(CW + 1 - AW){1'b0}}, base};
    i = {1'b0, idx};
    if (!rev) begin
      s = b + i;
      if (s >= (CW + 1)'(DEPTH)) begin
        s = s - (CW + 1)'(DEPTH);
      end
    end else begin
      s = b - i;
      if (b < i) begin
        s = s + (CW + 1)'(DEPTH);
      end
    end
    return s[AW-1:0];
  endfunction

  // Low bits of the fill count as shown in the result item.
  function automatic logic [COUNT_W-1:0] count_field(input cnt_t c);
    logic [CW+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

endpackage

/* sv/srs_store.sv */
// Pair store: single-port-write, registered-read memory of coordinate pairs.
module srs_store (
  input  logic             clk,
  input  srs_pkg::mem_req_t req,
  output srs_pkg::pair_t   rd_data
);
  import srs_pkg::*;

  pair_t mem [DEPTH];
  pair_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/srs_ctrl.sv */
// Stack controller: pointers, orientation flag, search walk and result forming.
module srs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srs_pkg::op_t      op,
  input  srs_pkg::pair_t    key,
  output srs_pkg::mem_req_t mem_req,
  input  srs_pkg::pair_t    rd_data,
  output logic              res_vld,
  output srs_pkg::res_t     res,
  input  logic              res_take
);
  import srs_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  addr_t  base_r, base_nxt;
  logic   rev_r, rev_nxt;
  pair_t  key_r, key_nxt;
  addr_t  ptr_r, ptr_nxt;
  cnt_t   left_r, left_nxt;
  logic   pend_r, pend_nxt;
  res_t   res_r, res_nxt;

  cnt_t   cnt_m1;
  cnt_t   cnt_new;
  logic   hit;

  assign cnt_m1 = cnt_r - CW'(1);
  assign hit    = (rd_data == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_POP:    state_nxt = (cnt_r != '0) ? ST_POP_WAIT : ST_DONE;
            OP_SEARCH: state_nxt = (cnt_r != '0) ? ST_SEARCH : ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_POP_WAIT: state_nxt = ST_DONE;
      ST_SEARCH: begin
        if (pend_r && (hit || left_r == '0)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory port
  always_comb begin
    in_stall        = 1'b1;
    res_vld         = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = phys_idx(base_r, rev_r, cnt_r);
    mem_req.wr_data = key;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = ptr_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && op == OP_PUSH && cnt_r < DEPTH_CNT) begin
          mem_req.wr_en = 1'b1;
        end
        if (in_valid && op == OP_POP && cnt_r != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = phys_idx(base_r, rev_r, cnt_m1);
        end
      end
      ST_SEARCH: begin
        mem_req.rd_en = (left_r != '0);
      end
      ST_DONE: res_vld = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    rev_nxt  = rev_r;
    key_nxt  = key_r;
    ptr_nxt  = ptr_r;
    left_nxt = left_r;
    pend_nxt = 1'b0;
    res_nxt  = res_r;
    cnt_new  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt      = key;
          res_nxt.ok   = 1'b0;
          res_nxt.pair = '0;
          case (op)
            OP_PUSH: begin
              if (cnt_r < DEPTH_CNT) begin
                cnt_new    = cnt_r + CW'(1);
                res_nxt.ok = 1'b1;
              end
            end
            OP_POP: begin
              if (cnt_r != '0) begin
                cnt_new    = cnt_m1;
                res_nxt.ok = 1'b1;
              end
            end
            OP_REVERSE: begin
              // reverse by moving the bottom to the old top and flipping direction
              res_nxt.ok = 1'b1;
              rev_nxt    = ~rev_r;
              if (cnt_r != '0) begin
                base_nxt = phys_idx(base_r, rev_r, cnt_m1);
              end
            end
            OP_SEARCH: begin
              ptr_nxt  = base_r;
              left_nxt = cnt_r;
            end
            default: ;
          endcase
          cnt_nxt       = cnt_new;
          res_nxt.empty = (cnt_new == '0);
          res_nxt.count = count_field(cnt_new);
        end
      end
      ST_POP_WAIT: res_nxt.pair = rd_data;
      ST_SEARCH: begin
        // issue one read a cycle, compare the data of the previous read
        if (left_r != '0) begin
          ptr_nxt  = phys_idx(ptr_r, rev_r, CW'(1));
          left_nxt = left_r - CW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && hit) begin
          res_nxt.ok = 1'b1;
          pend_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      base_r  <= '0;
      rev_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      rev_r   <= rev_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    ptr_r  <= ptr_nxt;
    left_r <= left_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

/* sv/searchable_reversible_stack_unit.sv */
// Push: the result is registered in the cycle after the accept.
// Reverse: it only moves the bottom pointer and flips the growth direction.
// Pop: passes through ST_POP_WAIT for the registered read of the pair memory.
// Search: one memory read per stored item at most; an empty stack skips the walk,
// and a match ends the walk early.
// Reset (rst_n low, synchronous) empties the stack; memory contents are left as they are.
module searchable_reversible_stack_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [7:0] out_row,
  output logic [7:0] out_col,
  output logic       out_empty_res,
  output logic [6:0] out_count
);
  import srs_pkg::*;

  mem_req_t mem_req;
  pair_t    rd_data;
  pair_t    key;
  logic     res_vld;
  logic     res_take;
  res_t     res;

  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r;

  assign key.row = in_row;
  assign key.col = in_col;

  srs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op_t'(in_operation)),
    .key      (key),
    .mem_req  (mem_req),
    .rd_data  (rd_data),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take)
  );

  srs_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // output register: loads when empty or being drained
  assign res_take = res_vld && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_res_r.ok;
  assign out_row       = out_res_r.pair.row;
  assign out_col       = out_res_r.pair.col;
  assign out_empty_res = out_res_r.empty;
  assign out_count     = out_res_r.count;

endmodule

/* sv/srs_chk.sv */
// Port-level checker for the stack unit, bound to the top level.
module srs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic [7:0] in_row,
  input logic [7:0] in_col,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_ok,
  input logic [7:0] out_row,
  input logic [7:0] out_col,
  input logic       out_empty_res,
  input logic [6:0] out_count
);

  // a stalled input item keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_operation) && $stable(in_row)
      && $stable(in_col))
    else $error("stalled input item changed");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_ok) && $stable(out_count))
    else $error("stalled result item changed");

  // one item at a time: the input stalls right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // a non-zero count never comes with the empty flag
  a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count != 7'd0 |-> !out_empty_res)
    else $error("empty flag with non-zero count");

  // coordinates only appear on a successful pop
  a_coord_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row != 8'd0 || out_col != 8'd0) |-> out_ok)
    else $error("coordinates reported without success");

endmodule

bind searchable_reversible_stack_unit srs_chk u_srs_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_operation  (in_operation),
  .in_row        (in_row),
  .in_col        (in_col),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ok        (out_ok),
  .out_row       (out_row),
  .out_col       (out_col),
  .out_empty_res (out_empty_res),
  .out_count     (out_count)
);

/* tb/tb.sv */
// Self-checking testbench for the searchable reversible stack unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = DEPTH + 16;
  localparam int RANDOM_ITEMS   = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_row;
  logic [7:0] in_col;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ok;
  logic [7:0] out_row;
  logic [7:0] out_col;
  logic       out_empty_res;
  logic [6:0] out_count;

  // Shadow copy of the stack contents and fill level
  pair_t stack_shadow [DEPTH];
  int    stack_fill;

  res_t  pending_results [$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  bit    no_idle;

  searchable_reversible_stack_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_empty_res (out_empty_res),
    .out_count     (out_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow stack and return the result it should give
  function automatic res_t predict_stack_op(input op_t op, input logic [7:0] row,
                                            input logic [7:0] col);
    res_t  r;
    pair_t key;
    pair_t tmp;
    int    lo;
    int    hi;
    r   = '0;
    key = {row, col};
    case (op)
      OP_PUSH: begin
        if (stack_fill < DEPTH) begin
          stack_shadow[stack_fill] = key;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.pair = stack_shadow[stack_fill];
          r.ok   = 1'b1;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = stack_fill - 1;
        while (lo < hi) begin
          tmp              = stack_shadow[lo];
          stack_shadow[lo] = stack_shadow[hi];
          stack_shadow[hi] = tmp;
          lo++;
          hi--;
        end
        r.ok = 1'b1;
      end
      default: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_shadow[i] == key) r.ok = 1'b1;
        end
      end
    endcase
    r.empty = (stack_fill == 0);
    r.count = COUNT_W'(stack_fill);
    return r;
  endfunction

  // Present one item from the falling edge and hold it until accepted
  task automatic issue_op(input op_t op, input logic [7:0] row, input logic [7:0] col);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < 7) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_row       = row;
    in_col       = col;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_stack_op(op, row, col));
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty-stack corners and single-pair handling
  task automatic test_empty_corners();
    issue_op(OP_POP, 8'h12, 8'h34);
    issue_op(OP_SEARCH, 8'h00, 8'h00);
    issue_op(OP_REVERSE, 8'hff, 8'hff);
    issue_op(OP_PUSH, 8'h00, 8'h00);
    issue_op(OP_REVERSE, 8'h00, 8'h00);
    issue_op(OP_SEARCH, 8'h00, 8'h00);
    issue_op(OP_SEARCH, 8'h00, 8'h01);
    issue_op(OP_POP, 8'hff, 8'hff);
    issue_op(OP_POP, 8'h00, 8'h00);
  endtask

  // Coordinate extremes, search hits and misses, reversal and pops
  task automatic test_field_extremes();
    issue_op(OP_PUSH, 8'hff, 8'hff);
    issue_op(OP_PUSH, 8'h00, 8'hff);
    issue_op(OP_PUSH, 8'hff, 8'h00);
    issue_op(OP_PUSH, 8'haa, 8'h55);
    issue_op(OP_PUSH, 8'h55, 8'haa);
    issue_op(OP_SEARCH, 8'hff, 8'hff);
    issue_op(OP_SEARCH, 8'h55, 8'haa);
    issue_op(OP_SEARCH, 8'haa, 8'haa);
    issue_op(OP_REVERSE, 8'h5a, 8'ha5);
    issue_op(OP_SEARCH, 8'h00, 8'hff);
    issue_op(OP_POP, 8'h5a, 8'ha5);
    issue_op(OP_POP, 8'h00, 8'h00);
    issue_op(OP_REVERSE, 8'h00, 8'h00);
    issue_op(OP_POP, 8'hff, 8'hff);
    issue_op(OP_POP, 8'h00, 8'h00);
    issue_op(OP_POP, 8'h00, 8'h00);
  endtask

  // Fill to capacity, push past it, search both ends, then empty it again
  task automatic test_full_stack();
    no_idle = 1'b1;
    for (int i = 0; i < DEPTH + 2; i++) begin
      issue_op(OP_PUSH, 8'(i * 3), 8'(255 - i));
    end
    issue_op(OP_SEARCH, 8'h00, 8'hff);
    issue_op(OP_SEARCH, 8'((DEPTH - 1) * 3), 8'(256 - DEPTH));
    issue_op(OP_REVERSE, 8'h00, 8'h00);
    issue_op(OP_SEARCH, 8'h00, 8'hff);
    issue_op(OP_PUSH, 8'h77, 8'h77);
    for (int i = 0; i < DEPTH + 1; i++) begin
      issue_op(OP_POP, 8'($urandom), 8'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Bursts with a drifting push bias so the fill level sweeps empty to full
  task automatic test_random_mix(input int n_items);
    int    push_pct;
    int    sent;
    int    burst;
    int    pick;
    pair_t key;
    sent  = 0;
    burst = 0;
    while (sent < n_items) begin
      push_pct = $urandom_range(90, 10);
      for (int k = 0; k < 100 && sent < n_items; k++) begin
        pick = $urandom_range(99);
        key  = pair_t'($urandom);
        if (pick < push_pct) begin
          // some pushes repeat a pair already held
          if (stack_fill > 0 && $urandom_range(9) == 0) begin
            key = stack_shadow[$urandom_range(stack_fill - 1)];
          end
          issue_op(OP_PUSH, key.row, key.col);
        end else begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            issue_op(OP_POP, key.row, key.col);
          end else if (pick < 60) begin
            issue_op(OP_REVERSE, key.row, key.col);
          end else begin
            if (stack_fill > 0 && $urandom_range(99) < 60) begin
              key = stack_shadow[$urandom_range(stack_fill - 1)];
            end
            issue_op(OP_SEARCH, key.row, key.col);
          end
        end
        sent++;
      end
      burst++;
      if (burst % 5 == 2) wait_drained();
    end
  endtask

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: ok=%0b row=%0d col=%0d empty=%0b count=%0d",
                   out_ok, out_row, out_col, out_empty_res, out_count);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok || out_row !== want.pair.row || out_col !== want.pair.col ||
            out_empty_res !== want.empty || out_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected ok=%0b row=%0d col=%0d empty=%0b count=%0d",
                     want.ok, want.pair.row, want.pair.col, want.empty, want.count);
            $display("          actual   ok=%0b row=%0d col=%0d empty=%0b count=%0d",
                     out_ok, out_row, out_col, out_empty_res, out_count);
          end
        end
      end
    end
  end

  // Receiver stalls at random, except during the no-idle stretch
  always @(negedge clk) begin
    out_stall = rst_n && !no_idle && ($urandom_range(99) < 7);
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_PUSH;
    in_row       = 8'h00;
    in_col       = 8'h00;
    no_idle      = 1'b0;
    stack_fill   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_corners();
    test_field_extremes();
    wait_drained();
    test_full_stack();
    test_random_mix(RANDOM_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
